// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: always");

// Antecedent in one cycle requires consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next");

`endif

// ===== sv/pstu_pkg.sv =====
package pstu_pkg;

  localparam int unsigned CountWidth = 9;

  localparam logic [CountWidth-1:0] DotLast = 9'd340;
  localparam logic [CountWidth-1:0] DotSkip = 9'd339;
  localparam logic [CountWidth-1:0] DotReset = 9'd21;
  localparam logic [CountWidth-1:0] LinePre = 9'd261;
  localparam logic [CountWidth-1:0] LineVblank = 9'd241;
  localparam logic [CountWidth-1:0] LineVisible = 9'd240;

  typedef enum logic [2:0] {
    FUNC_TICK   = 3'd0,
    FUNC_CTRL   = 3'd1,
    FUNC_MASK   = 3'd2,
    FUNC_SCROLL = 3'd3,
    FUNC_ADDR   = 3'd4,
    FUNC_WDATA  = 3'd5,
    FUNC_RDATA  = 3'd6,
    FUNC_STATUS = 3'd7
  } func_t;

  typedef struct packed {
    logic                  render_line;
    logic [CountWidth-1:0] dot;
    logic [CountWidth-1:0] line;
  } scroll_ctl_t;

endpackage

// ===== sv/pstu_in_if.sv =====
interface pstu_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] wdata;

  modport source (output valid, output func, output wdata, input ready);
  modport sink (input valid, input func, input wdata, output ready);
endinterface

// ===== sv/pstu_out_if.sv =====
interface pstu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [14:0] vram_addr;
  logic        vram_access;
  logic        vram_write;
  logic        nmi;
  logic [8:0]  scanline_now;
  logic [8:0]  dot_now;

  modport source (
    output valid, output read_data, output vram_addr, output vram_access,
    output vram_write, output nmi, output scanline_now, output dot_now,
    input ready
  );
  modport sink (
    input valid, input read_data, input vram_addr, input vram_access,
    input vram_write, input nmi, input scanline_now, input dot_now,
    output ready
  );
endinterface

// ===== sv/pstu_scroll.sv =====
module pstu_scroll (
  input  pstu_pkg::scroll_ctl_t ctl,
  input  logic [14:0]           cur_addr,
  input  logic [14:0]           temp_addr,
  output logic [14:0]           addr_next
);
  import pstu_pkg::*;

  logic [14:0] a_cx;
  logic [14:0] a_fy;
  logic [14:0] a_hc;
  logic        cx_en;
  logic        vcopy_en;

  function automatic logic [14:0] coarse_x_step(input logic [14:0] a);
    logic [14:0] r;
    r = a;
    if (a[4:0] == 5'd31) begin
      r[4:0] = 5'd0;
      r[10] = ~a[10];
    end else begin
      r = a + 15'd1;
    end
    return r;
  endfunction

  function automatic logic [14:0] fine_y_step(input logic [14:0] a);
    logic [14:0] r;
    logic [4:0]  y;
    r = a;
    y = a[9:5];
    if (a[14:12] != 3'd7) begin
      r[14:12] = a[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      if (y == 5'd29) begin
        y = 5'd0;
        r[11] = ~a[11];
      end else if (y == 5'd31) begin
        y = 5'd0;
      end else begin
        y = y + 5'd1;
      end
      r[9:5] = y;
    end
    return r;
  endfunction

  always_comb begin
    cx_en = (((ctl.dot > 9'd1) && (ctl.dot < 9'd258)) ||
             ((ctl.dot > 9'd320) && (ctl.dot < 9'd338))) && (ctl.dot[2:0] == 3'd0);
    vcopy_en = (ctl.line == LinePre) && (ctl.dot > 9'd279) && (ctl.dot < 9'd305);

    a_cx = cx_en ? coarse_x_step(cur_addr) : cur_addr;
    a_fy = (ctl.dot == 9'd256) ? fine_y_step(a_cx) : a_cx;
    a_hc = a_fy;
    if (ctl.dot == 9'd257) begin
      a_hc[10] = temp_addr[10];
      a_hc[4:0] = temp_addr[4:0];
    end
    addr_next = a_hc;
    if (vcopy_en) begin
      addr_next[14:11] = temp_addr[14:11];
      addr_next[9:5] = temp_addr[9:5];
    end
    if (!ctl.render_line) begin
      addr_next = cur_addr;
    end
  end

endmodule

// ===== sv/ppu_scroll_timing_unit.sv =====
// Picture-unit timing and scroll address unit.
// Channel in_ch carries one item per transfer: func selects a dot tick or one
// processor register access, wdata is the byte for the write accesses.
// Channel out_ch returns exactly one result per item, in order: status byte,
// data-access address and decode, NMI pulse, and the raster position after
// the item.
// Items pass an input register and then one combinational step into the
// result register, which loads only when out_ch is free; one item is taken
// every cycle while out_ch keeps ready high.
// When out_ch stalls, the result register holds and the input register keeps
// accepting one more item; in_ch.ready drops only when both are full.
// Reset empties both registers and puts the raster at line 0, dot 21 with all
// scroll, control and NMI state cleared; no result is pending after reset.
module ppu_scroll_timing_unit (
  input logic        clk,
  input logic        rst,
  pstu_in_if.sink    in_ch,
  pstu_out_if.source out_ch
);
  import pstu_pkg::*;

  logic                  in_q_valid;
  logic [2:0]            func_q;
  logic [7:0]            wdata_q;

  logic                  out_valid;
  logic                  out_free;
  logic                  fire;

  logic [14:0]           cur_addr, cur_addr_next;
  logic [14:0]           temp_addr, temp_addr_next;
  logic [2:0]            fine_x, fine_x_next;
  logic                  write_toggle, write_toggle_next;
  logic [7:0]            ctrl_bits, ctrl_bits_next;
  logic [7:0]            mask_bits, mask_bits_next;
  logic                  vblank_flag, vblank_flag_next;
  logic [CountWidth-1:0] line_count, line_count_next;
  logic [CountWidth-1:0] dot_count, dot_count_next;
  logic                  odd_frame, odd_frame_next;
  logic                  last_ctrl_nmi, last_ctrl_nmi_next;
  logic                  last_vblank, last_vblank_next;
  logic                  nmi_armed, nmi_armed_next;

  logic [7:0]            read_data_next;
  logic [14:0]           vram_addr_next;
  logic                  vram_access_next;
  logic                  vram_write_next;
  logic                  nmi_next;

  logic [7:0]            read_data;
  logic [14:0]           vram_addr;
  logic                  vram_access;
  logic                  vram_write;
  logic                  nmi;

  logic                  rendering;
  scroll_ctl_t           sctl;
  logic [14:0]           tick_addr;

  assign out_free = !out_valid || out_ch.ready;
  assign fire = in_q_valid && out_free;
  assign in_ch.ready = !in_q_valid || out_free;

  assign rendering = mask_bits[3] || mask_bits[4];
  assign sctl.render_line = rendering && ((line_count < LineVisible) || (line_count == LinePre));
  assign sctl.dot = dot_count;
  assign sctl.line = line_count;

  pstu_scroll u_scroll (
    .ctl       (sctl),
    .cur_addr  (cur_addr),
    .temp_addr (temp_addr),
    .addr_next (tick_addr)
  );

  always_comb begin
    cur_addr_next = cur_addr;
    temp_addr_next = temp_addr;
    fine_x_next = fine_x;
    write_toggle_next = write_toggle;
    ctrl_bits_next = ctrl_bits;
    mask_bits_next = mask_bits;
    vblank_flag_next = vblank_flag;
    line_count_next = line_count;
    dot_count_next = dot_count;
    odd_frame_next = odd_frame;
    last_ctrl_nmi_next = last_ctrl_nmi;
    last_vblank_next = last_vblank;
    nmi_armed_next = nmi_armed;
    read_data_next = 8'd0;
    vram_addr_next = 15'd0;
    vram_access_next = 1'b0;
    vram_write_next = 1'b0;
    nmi_next = 1'b0;

    case (func_t'(func_q))
      FUNC_TICK: begin
        cur_addr_next = tick_addr;
        if (line_count == LineVblank && dot_count == 9'd1) begin
          vblank_flag_next = 1'b1;
        end
        if (line_count == LinePre && dot_count == 9'd1) begin
          vblank_flag_next = 1'b0;
        end
        if (last_vblank != vblank_flag_next) begin
          nmi_armed_next = 1'b1;
          last_vblank_next = vblank_flag_next;
        end
        if (last_ctrl_nmi != ctrl_bits[7]) begin
          nmi_armed_next = 1'b1;
          last_ctrl_nmi_next = ctrl_bits[7];
        end
        if (nmi_armed_next && vblank_flag_next && ctrl_bits[7]) begin
          nmi_next = 1'b1;
          nmi_armed_next = 1'b0;
        end
        if ((dot_count >= DotLast) ||
            (dot_count == DotSkip && odd_frame && rendering && line_count == LinePre)) begin
          dot_count_next = '0;
          if (line_count >= LinePre) begin
            line_count_next = '0;
            odd_frame_next = !odd_frame;
          end else begin
            line_count_next = line_count + 9'd1;
          end
        end else begin
          dot_count_next = dot_count + 9'd1;
        end
      end
      FUNC_CTRL: begin
        ctrl_bits_next = wdata_q;
        temp_addr_next[11:10] = wdata_q[1:0];
      end
      FUNC_MASK: begin
        mask_bits_next = wdata_q;
      end
      FUNC_SCROLL: begin
        if (!write_toggle) begin
          temp_addr_next[4:0] = wdata_q[7:3];
          fine_x_next = wdata_q[2:0];
          write_toggle_next = 1'b1;
        end else begin
          temp_addr_next[14:12] = wdata_q[2:0];
          temp_addr_next[9:5] = wdata_q[7:3];
          write_toggle_next = 1'b0;
        end
      end
      FUNC_ADDR: begin
        if (!write_toggle) begin
          temp_addr_next[14] = 1'b0;
          temp_addr_next[13:8] = wdata_q[5:0];
          write_toggle_next = 1'b1;
        end else begin
          temp_addr_next[7:0] = wdata_q;
          cur_addr_next = {temp_addr[14:8], wdata_q};
          write_toggle_next = 1'b0;
        end
      end
      FUNC_WDATA, FUNC_RDATA: begin
        vram_addr_next = cur_addr;
        vram_access_next = (cur_addr[14:12] == 3'b010);
        vram_write_next = (func_t'(func_q) == FUNC_WDATA);
        cur_addr_next = cur_addr + (ctrl_bits[2] ? 15'd32 : 15'd1);
      end
      FUNC_STATUS: begin
        read_data_next = {vblank_flag, 7'd0};
        vblank_flag_next = 1'b0;
        write_toggle_next = 1'b0;
      end
      default: begin
        read_data_next = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_q_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      func_q <= in_ch.func;
      wdata_q <= in_ch.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_q_valid;
    end
    if (fire) begin
      read_data <= read_data_next;
      vram_addr <= vram_addr_next;
      vram_access <= vram_access_next;
      vram_write <= vram_write_next;
      nmi <= nmi_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_addr <= '0;
      temp_addr <= '0;
      fine_x <= '0;
      write_toggle <= 1'b0;
      ctrl_bits <= '0;
      mask_bits <= '0;
      vblank_flag <= 1'b0;
      line_count <= '0;
      dot_count <= DotReset;
      odd_frame <= 1'b0;
      last_ctrl_nmi <= 1'b0;
      last_vblank <= 1'b0;
      nmi_armed <= 1'b0;
    end else if (fire) begin
      cur_addr <= cur_addr_next;
      temp_addr <= temp_addr_next;
      fine_x <= fine_x_next;
      write_toggle <= write_toggle_next;
      ctrl_bits <= ctrl_bits_next;
      mask_bits <= mask_bits_next;
      vblank_flag <= vblank_flag_next;
      line_count <= line_count_next;
      dot_count <= dot_count_next;
      odd_frame <= odd_frame_next;
      last_ctrl_nmi <= last_ctrl_nmi_next;
      last_vblank <= last_vblank_next;
      nmi_armed <= nmi_armed_next;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.read_data = read_data;
  assign out_ch.vram_addr = vram_addr;
  assign out_ch.vram_access = vram_access;
  assign out_ch.vram_write = vram_write;
  assign out_ch.nmi = nmi;
  assign out_ch.scanline_now = line_count;
  assign out_ch.dot_now = dot_count;

endmodule

// ===== sv/pstu_checker.sv =====
`include "assert_macros.svh"

module pstu_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  read_data,
  input logic [14:0] vram_addr,
  input logic        vram_access,
  input logic        nmi,
  input logic [8:0]  scanline_now,
  input logic [8:0]  dot_now
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_ALWAYS(a_nmi_alone, clk, rst, !(out_valid && nmi) || (read_data == 8'd0 && vram_addr == 15'd0))
  `ASSERT_ALWAYS(a_access_decode, clk, rst, !(out_valid && vram_access) || (vram_addr[14:12] == 3'b010))
  `ASSERT_ALWAYS(a_raster_range, clk, rst, !out_valid || (dot_now <= 9'd340 && scanline_now <= 9'd261))

endmodule

bind ppu_scroll_timing_unit pstu_checker u_pstu_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .read_data    (out_ch.read_data),
  .vram_addr    (out_ch.vram_addr),
  .vram_access  (out_ch.vram_access),
  .nmi          (out_ch.nmi),
  .scanline_now (out_ch.scanline_now),
  .dot_now      (out_ch.dot_now)
);
